### rtl/assert_macros.svh
// Assertion helpers shared by the cron field mask parser RTL.
// Each macro samples on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge.
`define CFMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define CFMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cfmp_pkg.sv
package cfmp_pkg;

  // Field widths, which are also the field limits.
  localparam int unsigned MinuteW = 60;
  localparam int unsigned HourW   = 24;
  localparam int unsigned DayW    = 31;
  localparam int unsigned MonthW  = 12;
  localparam int unsigned WdayW   = 7;
  localparam int unsigned MaskW   = MinuteW;

  localparam int unsigned NumW  = 7;   // number accumulator
  localparam int unsigned LimW  = 6;   // field limit, at most 60
  localparam int unsigned FidxW = 3;   // field index, 0 to 5
  localparam int unsigned ProdW = 11;  // accumulator times ten plus a digit

  localparam logic [NumW-1:0] NumSat = 7'd127;

  localparam logic [FidxW-1:0] FieldMinute  = 3'd0;
  localparam logic [FidxW-1:0] FieldHour    = 3'd1;
  localparam logic [FidxW-1:0] FieldDay     = 3'd2;
  localparam logic [FidxW-1:0] FieldMonth   = 3'd3;
  localparam logic [FidxW-1:0] FieldWeekday = 3'd4;
  localparam logic [FidxW-1:0] FieldCount   = 3'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharDash    = 8'h2D;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharSlash   = 8'h2F;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [MinuteW-1:0] minute_mask;
    logic [HourW-1:0]   hour_mask;
    logic [DayW-1:0]    day_mask;
    logic [MonthW-1:0]  month_mask;
    logic [WdayW-1:0]   weekday_mask;
    logic               bad_char;
  } out_item_t;

  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_BLANK = 3'd1,
    CL_STAR  = 3'd2,
    CL_DASH  = 3'd3,
    CL_SLASH = 3'd4,
    CL_COMMA = 3'd5,
    CL_OTHER = 3'd6
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [6:0] {
    PH_BLANK    = 7'b0000001,
    PH_LOW      = 7'b0000010,
    PH_HIGH     = 7'b0000100,
    PH_STEP     = 7'b0001000,
    PH_STAR     = 7'b0010000,
    PH_STARSTEP = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_e;

  function automatic logic [LimW-1:0] field_limit(input logic [FidxW-1:0] idx);
    logic [LimW-1:0] lim;
    case (idx)
      FieldMinute:  lim = LimW'(MinuteW);
      FieldHour:    lim = LimW'(HourW);
      FieldDay:     lim = LimW'(DayW);
      FieldMonth:   lim = LimW'(MonthW);
      FieldWeekday: lim = LimW'(WdayW);
      default:      lim = '0;
    endcase
    return lim;
  endfunction

  function automatic logic [MaskW-1:0] mask_below(input logic [LimW-1:0] lim);
    logic [MaskW-1:0] m;
    m = '0;
    for (int i = 0; i < MaskW; i++) begin
      m[i] = (LimW'(i) < lim);
    end
    return m;
  endfunction

  // Bits lo..hi inclusive, clipped to the field limit.
  function automatic logic [MaskW-1:0] span_mask(input logic [NumW-1:0] lo,
                                                 input logic [NumW-1:0] hi,
                                                 input logic [LimW-1:0] lim);
    logic [MaskW-1:0] m;
    m = '0;
    for (int i = 0; i < MaskW; i++) begin
      m[i] = (NumW'(i) >= lo) && (NumW'(i) <= hi) && (LimW'(i) < lim);
    end
    return m;
  endfunction

endpackage

### rtl/cfmp_front.sv
module cfmp_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfmp_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cfmp_pkg::token_t   tok_o
);
  import cfmp_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Reduce each character to a class and a digit value.
  always_comb begin
    tok_o.digit = 4'(in_data_i.ch - CharZero);
    tok_o.last  = in_data_i.last;
    if (in_data_i.ch inside {[CharZero:CharNine]}) begin
      tok_o.cls = CL_DIGIT;
    end else if (in_data_i.ch inside {CharSpace, CharTab, CharNewline}) begin
      tok_o.cls = CL_BLANK;
    end else begin
      case (in_data_i.ch)
        CharStar:  tok_o.cls = CL_STAR;
        CharDash:  tok_o.cls = CL_DASH;
        CharSlash: tok_o.cls = CL_SLASH;
        CharComma: tok_o.cls = CL_COMMA;
        default:   tok_o.cls = CL_OTHER;
      endcase
    end
  end

endmodule

### rtl/cfmp_queue.sv
`include "assert_macros.svh"

module cfmp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfmp_pkg::token_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cfmp_pkg::token_t data_o
);
  import cfmp_pkg::*;

  token_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CFMP_ASSERT_IMP(a_no_push_full, push_i, !full_o, "token written into a full queue")
  `CFMP_ASSERT_IMP(a_no_pop_empty, pop_i, count_q != '0, "token taken from an empty queue")

endmodule

### rtl/cfmp_back.sv
`include "assert_macros.svh"

module cfmp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  input  cfmp_pkg::token_t    tok_i,
  output logic                tok_pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output cfmp_pkg::out_item_t res_o
);
  import cfmp_pkg::*;

  typedef enum logic [3:0] {
    ST_CONSUME = 4'b0001,
    ST_WALK    = 4'b0010,
    ST_FINAL   = 4'b0100,
    ST_EMIT    = 4'b1000
  } back_state_e;

  back_state_e        state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [FidxW-1:0]   fidx_q, fidx_d;
  logic [NumW-1:0]    accum_q, accum_d;
  logic [NumW-1:0]    rlow_q, rlow_d;
  logic [MaskW-1:0]   rbits_q, rbits_d;
  logic [MaskW-1:0]   fbits_q, fbits_d;
  logic [MinuteW-1:0] min_q, min_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [DayW-1:0]    day_q, day_d;
  logic [MonthW-1:0]  mon_q, mon_d;
  logic [WdayW-1:0]   wday_q, wday_d;
  logic               err_q, err_d;
  logic               walked_q, walked_d;
  logic               walk_fin_q, walk_fin_d;
  logic [NumW:0]      walk_idx_q, walk_idx_d;

  logic [LimW-1:0]  lim;
  logic [MaskW-1:0] lim_mask;
  logic             ignore;
  logic             enter_cls;
  logic             step_phase;
  phase_e           eff_phase;
  logic [NumW-1:0]  eff_accum;
  logic [ProdW-1:0] acc_prod;
  logic [NumW-1:0]  acc_next;
  logic [MaskW-1:0] span_pt;
  logic [MaskW-1:0] span_rng;
  logic [MaskW-1:0] close_add;
  logic             need_walk;
  logic [NumW-1:0]  step_n;
  logic [MaskW-1:0] fin_bits;
  logic [FidxW-1:0] fidx_inc;
  logic             do_close;
  logic             do_finish;

  assign lim       = field_limit(fidx_q);
  assign lim_mask  = mask_below(lim);
  assign ignore    = (phase_q == PH_DONE) || (fidx_q >= FieldCount);
  assign enter_cls = (tok_i.cls == CL_DIGIT) || (tok_i.cls == CL_DASH) ||
                     (tok_i.cls == CL_COMMA) || (tok_i.cls == CL_SLASH);
  assign step_phase = (phase_q == PH_STEP) || (phase_q == PH_STARSTEP);

  // A character that opens a field from the blank phase starts a fresh number.
  assign eff_phase = (phase_q == PH_BLANK && enter_cls) ? PH_LOW : phase_q;
  assign eff_accum = (phase_q == PH_BLANK) ? '0 : accum_q;

  assign acc_prod = ProdW'(eff_accum) * ProdW'(10) + ProdW'(tok_i.digit);
  assign acc_next = (acc_prod > ProdW'(NumSat)) ? NumSat : acc_prod[NumW-1:0];

  assign span_pt  = span_mask(eff_accum, eff_accum, lim);
  assign span_rng = span_mask(rlow_q, eff_accum, lim);

  // Stepped elements are closed by the walk, not here.
  always_comb begin
    case (eff_phase)
      PH_LOW:  close_add = span_pt;
      PH_HIGH: close_add = span_rng;
      PH_STAR: close_add = lim_mask;
      default: close_add = '0;
    endcase
  end

  assign need_walk = !ignore && !walked_q && step_phase &&
                     ((tok_i.cls == CL_BLANK) ||
                      (tok_i.cls == CL_COMMA && phase_q == PH_STEP));

  assign step_n   = (accum_q == '0) ? NumW'(1) : accum_q;
  assign fidx_inc = fidx_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fidx_d     = fidx_q;
    accum_d    = accum_q;
    rlow_d     = rlow_q;
    rbits_d    = rbits_q;
    fbits_d    = fbits_q;
    min_d      = min_q;
    hour_d     = hour_q;
    day_d      = day_q;
    mon_d      = mon_q;
    wday_d     = wday_q;
    err_d      = err_q;
    walked_d   = walked_q;
    walk_fin_d = walk_fin_q;
    walk_idx_d = walk_idx_q;
    tok_pop_o  = 1'b0;
    res_valid_o = 1'b0;
    do_close   = 1'b0;
    do_finish  = 1'b0;
    fin_bits   = '0;

    case (state_q)
      ST_CONSUME: begin
        if (tok_valid_i && need_walk) begin
          state_d    = ST_WALK;
          walk_idx_d = {1'b0, rlow_q};
          walk_fin_d = 1'b0;
        end else if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          walked_d  = 1'b0;
          if (tok_i.last) begin
            state_d = ST_FINAL;
          end
          if (!ignore) begin
            if (phase_q == PH_BLANK && tok_i.cls == CL_STAR) begin
              phase_d = PH_STAR;
              rlow_d  = '0;
              rbits_d = lim_mask;
              accum_d = '0;
            end else if (phase_q == PH_BLANK && !enter_cls) begin
              err_d = err_q || (tok_i.cls != CL_BLANK);
            end else if (tok_i.cls == CL_DIGIT && eff_phase != PH_STAR) begin
              phase_d = eff_phase;
              accum_d = acc_next;
            end else if (tok_i.cls == CL_BLANK) begin
              do_close  = 1'b1;
              do_finish = 1'b1;
            end else begin
              phase_d = eff_phase;
              accum_d = eff_accum;
              case (eff_phase)
                PH_LOW: begin
                  case (tok_i.cls)
                    CL_DASH: begin
                      rlow_d  = eff_accum;
                      accum_d = '0;
                      phase_d = PH_HIGH;
                    end
                    CL_SLASH: begin
                      rlow_d  = eff_accum;
                      rbits_d = span_pt;
                      accum_d = '0;
                      phase_d = PH_STEP;
                    end
                    CL_COMMA: do_close = 1'b1;
                    default:  err_d = 1'b1;
                  endcase
                end
                PH_HIGH: begin
                  case (tok_i.cls)
                    CL_SLASH: begin
                      rbits_d = span_rng;
                      accum_d = '0;
                      phase_d = PH_STEP;
                    end
                    CL_COMMA: begin
                      do_close = 1'b1;
                      phase_d  = PH_LOW;
                    end
                    default: err_d = 1'b1;
                  endcase
                end
                PH_STEP: begin
                  if (tok_i.cls == CL_COMMA) begin
                    do_close = 1'b1;
                    phase_d  = PH_LOW;
                  end else begin
                    err_d = 1'b1;
                  end
                end
                PH_STAR: begin
                  if (tok_i.cls == CL_SLASH) begin
                    accum_d = '0;
                    phase_d = PH_STARSTEP;
                  end else begin
                    err_d = 1'b1;
                  end
                end
                default: err_d = 1'b1;
              endcase
            end
          end
        end
      end

      // Visit one candidate value a cycle, from the range start by the step.
      ST_WALK: begin
        if (walk_idx_q < (NumW + 1)'(lim)) begin
          fbits_d[walk_idx_q[LimW-1:0]] = fbits_q[walk_idx_q[LimW-1:0]] |
                                          rbits_q[walk_idx_q[LimW-1:0]];
          walk_idx_d = walk_idx_q + (NumW + 1)'(step_n);
        end else begin
          walked_d = 1'b1;
          state_d  = walk_fin_q ? ST_FINAL : ST_CONSUME;
        end
      end

      ST_FINAL: begin
        if (phase_q != PH_BLANK && phase_q != PH_DONE) begin
          if (step_phase && !walked_q) begin
            state_d    = ST_WALK;
            walk_idx_d = {1'b0, rlow_q};
            walk_fin_d = 1'b1;
          end else begin
            do_close  = 1'b1;
            do_finish = 1'b1;
            walked_d  = 1'b0;
          end
        end else begin
          // Fields never begun get bit 0 alone.
          if (fidx_q <= FieldMinute)  min_d  = MinuteW'(1);
          if (fidx_q <= FieldHour)    hour_d = HourW'(1);
          if (fidx_q <= FieldDay)     day_d  = DayW'(1);
          if (fidx_q <= FieldMonth)   mon_d  = MonthW'(1);
          if (fidx_q <= FieldWeekday) wday_d = WdayW'(1);
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d    = ST_CONSUME;
          phase_d    = PH_BLANK;
          fidx_d     = FieldMinute;
          accum_d    = '0;
          rlow_d     = '0;
          rbits_d    = '0;
          fbits_d    = '0;
          min_d      = '0;
          hour_d     = '0;
          day_d      = '0;
          mon_d      = '0;
          wday_d     = '0;
          err_d      = 1'b0;
          walked_d   = 1'b0;
          walk_fin_d = 1'b0;
        end
      end

      default: state_d = ST_CONSUME;
    endcase

    if (do_close) begin
      fbits_d = fbits_q | close_add;
      accum_d = '0;
    end

    if (do_finish) begin
      fin_bits = fbits_d & lim_mask;
      case (fidx_q)
        FieldMinute:  min_d  = fin_bits[MinuteW-1:0];
        FieldHour:    hour_d = fin_bits[HourW-1:0];
        FieldDay:     day_d  = fin_bits[DayW-1:0];
        FieldMonth:   mon_d  = fin_bits[MonthW-1:0];
        FieldWeekday: wday_d = fin_bits[WdayW-1:0];
        default:      fin_bits = '0;
      endcase
      fbits_d = '0;
      accum_d = '0;
      rlow_d  = '0;
      rbits_d = '0;
      fidx_d  = fidx_inc;
      phase_d = (fidx_inc >= FieldCount) ? PH_DONE : PH_BLANK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CONSUME;
      phase_q    <= PH_BLANK;
      fidx_q     <= FieldMinute;
      accum_q    <= '0;
      rlow_q     <= '0;
      rbits_q    <= '0;
      fbits_q    <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      mon_q      <= '0;
      wday_q     <= '0;
      err_q      <= 1'b0;
      walked_q   <= 1'b0;
      walk_fin_q <= 1'b0;
      walk_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      fidx_q     <= fidx_d;
      accum_q    <= accum_d;
      rlow_q     <= rlow_d;
      rbits_q    <= rbits_d;
      fbits_q    <= fbits_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      day_q      <= day_d;
      mon_q      <= mon_d;
      wday_q     <= wday_d;
      err_q      <= err_d;
      walked_q   <= walked_d;
      walk_fin_q <= walk_fin_d;
      walk_idx_q <= walk_idx_d;
    end
  end

  assign res_o.minute_mask  = min_q;
  assign res_o.hour_mask    = hour_q;
  assign res_o.day_mask     = day_q;
  assign res_o.month_mask   = mon_q;
  assign res_o.weekday_mask = wday_q;
  assign res_o.bad_char     = err_q;

  `CFMP_ASSERT(a_fbits_in_limit, (fbits_q & ~lim_mask) == '0,
               "field bits set at or above the field limit")
  `CFMP_ASSERT(a_done_at_end, (phase_q == PH_DONE) == (fidx_q == FieldCount),
               "done phase out of step with the field index")
  `CFMP_ASSERT_NXT(a_walk_advances, (state_q == ST_WALK) && (walk_idx_q < (NumW + 1)'(lim)),
                   walk_idx_q > $past(walk_idx_q), "step walk failed to advance")

endmodule

### rtl/cron_field_mask_parser.sv
// Cron field mask parser: feed a five-field cron specification (minute, hour, day,
// month, weekday) one ASCII character per input transfer, marking the final character
// with last; one output transfer then carries a bit mask per field plus bad_char, and
// the block is back in its reset state for the next specification. Fields take '*',
// numbers, ranges a-b, steps /n (a zero or empty step acts as /1) and comma lists;
// values at or above a field's limit are dropped, numbers saturate at 127, fields not
// reached before the end get bit 0 alone, and any character that does not fit the
// grammar before the fifth field ends sets bad_char. Characters enter a four-entry token
// queue at one per cycle while it is not full; the parser behind it takes one token per
// cycle, except that closing a stepped element walks its candidate values one per cycle
// (sixty for a minute step of one), the last character is followed by the close, fill
// and load of the output register, and a result waits while that register is occupied.
// The walk of the stepped element sets the sustained rate for step-heavy text.
`include "assert_macros.svh"

module cron_field_mask_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfmp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfmp_pkg::out_item_t out_data_o
);
  import cfmp_pkg::*;

  logic      push;
  token_t    push_tok;
  logic      q_full;
  logic      q_valid;
  token_t    q_tok;
  logic      q_pop;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // Classify characters on the way in.
  cfmp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  // Decouple intake from parsing so a long step walk does not stall the sender at once.
  cfmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_tok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_tok)
  );

  cfmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .tok_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: take a new result when empty or while the current one transfers.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the transfer completes.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CFMP_ASSERT_IMP(a_emit_into_free_slot, res_valid, res_ready,
                   "result emitted while the output register is occupied")

endmodule

### dv/cron_field_mask_parser_tb.sv
`timescale 1ns / 1ps

module cron_field_mask_parser_tb;
  import cfmp_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;  // cycles with no transfer on either side
  localparam int unsigned RandomChars   = 560;
  localparam int unsigned RandomSpecs   = 24;
  localparam int unsigned QuietFrom     = 420;   // drop all idling after this many chars
  localparam int unsigned SettleCycles  = 100;   // longest step walk plus output load

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_data     = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  out_item_t out_data_o;

  cron_field_mask_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Mask predictor: a private copy of the parser state, advanced one character
  // per accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [FidxW-1:0]   fld;        // field being parsed, 5 once all are closed
  phase_e             ph;
  logic [NumW-1:0]    acc;        // saturating decimal accumulator
  logic [NumW-1:0]    lo_num;     // start of the current range or step
  logic [MaskW-1:0]   run_mask;   // candidates that a step thins out
  logic [MaskW-1:0]   fld_mask;   // bits gathered for the open field
  logic [MinuteW-1:0] got_min;
  logic [HourW-1:0]   got_hour;
  logic [DayW-1:0]    got_day;
  logic [MonthW-1:0]  got_mon;
  logic [WdayW-1:0]   got_wday;
  logic               saw_bad;

  function automatic int unsigned limit_of(input int unsigned f);
    case (f)
      FieldMinute:  return MinuteW;
      FieldHour:    return HourW;
      FieldDay:     return DayW;
      FieldMonth:   return MonthW;
      FieldWeekday: return WdayW;
      default:      return 0;
    endcase
  endfunction

  // Bits lo..hi inclusive, clipped to the limit of the open field.
  function automatic logic [MaskW-1:0] bits_between(input int unsigned lo, input int unsigned hi);
    logic [MaskW-1:0] m;
    int unsigned      lim;
    int unsigned      top;
    m   = '0;
    lim = limit_of(fld);
    if (lo > hi || lo >= lim) return m;
    top = (hi < lim) ? hi : lim - 1;
    for (int unsigned i = lo; i <= top; i++) m[i] = 1'b1;
    return m;
  endfunction

  // Keep every n-th candidate counting from start; a zero step acts as one.
  function automatic logic [MaskW-1:0] every_nth(input logic [MaskW-1:0] m,
                                                 input int unsigned start,
                                                 input int unsigned n);
    logic [MaskW-1:0] keep;
    int unsigned      lim;
    int unsigned      stride;
    keep   = '0;
    lim    = limit_of(fld);
    stride = (n == 0) ? 1 : n;
    for (int unsigned i = start; i < lim; i += stride) keep[i] = 1'b1;
    return m & keep;
  endfunction

  function automatic void clear_parse();
    fld      = FieldMinute;
    ph       = PH_BLANK;
    acc      = '0;
    lo_num   = '0;
    run_mask = '0;
    fld_mask = '0;
    got_min  = '0;
    got_hour = '0;
    got_day  = '0;
    got_mon  = '0;
    got_wday = '0;
    saw_bad  = 1'b0;
  endfunction

  function automatic void close_elem();
    case (ph)
      PH_LOW:               fld_mask |= bits_between(acc, acc);
      PH_HIGH:              fld_mask |= bits_between(lo_num, acc);
      PH_STEP, PH_STARSTEP: fld_mask |= every_nth(run_mask, lo_num, acc);
      PH_STAR:              fld_mask |= bits_between(0, NumSat);
      default: ;
    endcase
    acc = '0;
  endfunction

  function automatic void end_field();
    logic [MaskW-1:0] v;
    v = fld_mask & bits_between(0, NumSat);
    case (fld)
      FieldMinute:  got_min  = v;
      FieldHour:    got_hour = v[HourW-1:0];
      FieldDay:     got_day  = v[DayW-1:0];
      FieldMonth:   got_mon  = v[MonthW-1:0];
      FieldWeekday: got_wday = v[WdayW-1:0];
      default: ;
    endcase
    fld_mask = '0;
    acc      = '0;
    lo_num   = '0;
    run_mask = '0;
    if (fld < FieldCount) fld = fld + 1'b1;
    ph = (fld >= FieldCount) ? PH_DONE : PH_BLANK;
  endfunction

  function automatic void eat_char(input logic [7:0] c);
    bit          is_blank;
    bit          is_digit;
    int unsigned sum;
    is_blank = (c == CharSpace || c == CharTab || c == CharNewline);
    is_digit = (c >= CharZero && c <= CharNine);
    // Trailing text after the fifth field is ignored without complaint.
    if (ph == PH_DONE || fld >= FieldCount) return;
    if (ph == PH_BLANK) begin
      if (is_blank) return;
      if (c == CharStar) begin
        ph       = PH_STAR;
        lo_num   = '0;
        run_mask = bits_between(0, NumSat);
        acc      = '0;
        return;
      end
      if (!(is_digit || c == CharDash || c == CharComma || c == CharSlash)) begin
        saw_bad = 1'b1;
        return;
      end
      ph  = PH_LOW;
      acc = '0;
    end
    if (is_digit && ph != PH_STAR) begin
      sum = 10 * acc + c - CharZero;
      acc = (sum > NumSat) ? NumSat : NumW'(sum);
      return;
    end
    // Once the field has begun, a blank closes the element and the field.
    if (is_blank) begin
      close_elem();
      end_field();
      return;
    end
    case (ph)
      PH_LOW: begin
        if (c == CharDash) begin
          lo_num = acc;
          acc    = '0;
          ph     = PH_HIGH;
        end else if (c == CharSlash) begin
          lo_num   = acc;
          run_mask = bits_between(acc, acc);
          acc      = '0;
          ph       = PH_STEP;
        end else if (c == CharComma) begin
          close_elem();
        end else begin
          saw_bad = 1'b1;
        end
      end
      PH_HIGH: begin
        if (c == CharSlash) begin
          run_mask = bits_between(lo_num, acc);
          acc      = '0;
          ph       = PH_STEP;
        end else if (c == CharComma) begin
          close_elem();
          ph = PH_LOW;
        end else begin
          saw_bad = 1'b1;
        end
      end
      PH_STEP: begin
        if (c == CharComma) begin
          close_elem();
          ph = PH_LOW;
        end else begin
          saw_bad = 1'b1;
        end
      end
      PH_STAR: begin
        if (c == CharSlash) begin
          acc = '0;
          ph  = PH_STARSTEP;
        end else begin
          saw_bad = 1'b1;
        end
      end
      default: saw_bad = 1'b1;
    endcase
  endfunction

  // Advance by one character; on the last one produce the masks and start afresh.
  function automatic bit predict_masks(input in_item_t it, output out_item_t res);
    res = '0;
    eat_char(it.ch);
    if (!it.last) return 1'b0;
    if (ph != PH_BLANK && ph != PH_DONE) begin
      close_elem();
      end_field();
    end
    // Fields never begun match value 0 alone.
    while (fld < FieldCount) begin
      fld_mask = 1;
      end_field();
    end
    res.minute_mask  = got_min;
    res.hour_mask    = got_hour;
    res.day_mask     = got_day;
    res.month_mask   = got_mon;
    res.weekday_mask = got_wday;
    res.bad_char     = saw_bad;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic out_item_t masks_of(input logic [MinuteW-1:0] m, input logic [HourW-1:0] h,
                                         input logic [DayW-1:0] d, input logic [MonthW-1:0] mo,
                                         input logic [WdayW-1:0] w, input logic bad);
    out_item_t r;
    r.minute_mask  = m;
    r.hour_mask    = h;
    r.day_mask     = d;
    r.month_mask   = mo;
    r.weekday_mask = w;
    r.bad_char     = bad;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected masks and the output checker
  // ---------------------------------------------------------------------------
  out_item_t   pending_masks[$];
  int unsigned mismatches = 0;

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Compare every output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: result with nothing expected, got %h", out_data_o);
      end else begin
        want = pending_masks.pop_front();
        check_field("minute_mask",  want.minute_mask,  out_data_o.minute_mask);
        check_field("hour_mask",    want.hour_mask,    out_data_o.hour_mask);
        check_field("day_mask",     want.day_mask,     out_data_o.day_mask);
        check_field("month_mask",   want.month_mask,   out_data_o.month_mask);
        check_field("weekday_mask", want.weekday_mask, out_data_o.weekday_mask);
        check_field("bad_char",     want.bad_char,     out_data_o.bad_char);
      end
    end
  end

  // Watchdog: end the run if neither side moves a transfer for too long.
  int unsigned stuck_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure: random stall bursts, none once the run goes quiet.
  // ---------------------------------------------------------------------------
  bit quiet = 1'b0;

  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 1) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character driver
  // ---------------------------------------------------------------------------
  logic [7:0]  spec_q[$];          // specification text waiting to be sent
  bit          row_typed = 1'b0;   // expectation typed in rather than predicted
  out_item_t   row_want;
  int unsigned chars_sent = 0;

  // Send one character; hold valid and payload until the transfer completes.
  task automatic send_char(input logic [7:0] c, input logic lst);
    bit        has_res;
    out_item_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: c, last: lst};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_res = predict_masks('{ch: c, last: lst}, res);
    if (has_res) pending_masks.push_back(row_typed ? row_want : res);
    chars_sent++;
  endtask

  // Send the whole queued specification, marking the final character as last.
  task automatic send_spec();
    for (int i = 0; i < spec_q.size(); i++)
      send_char(spec_q[i], i == spec_q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Random specification builder
  // ---------------------------------------------------------------------------
  function automatic void put_num(input int v);
    if (v < 0) return;  // empty number
    if (v >= 100) spec_q.push_back(CharZero + 8'(v / 100));
    if (v >= 10)  spec_q.push_back(CharZero + 8'((v / 10) % 10));
    spec_q.push_back(CharZero + 8'(v % 10));
  endfunction

  // Mostly in range; now and then empty, beyond the limit or saturating.
  function automatic int pick_num(input int unsigned lim);
    case ($urandom_range(0, 15))
      0:       return -1;
      1:       return $urandom_range(lim, 999);
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  function automatic int pick_step(input int unsigned lim);
    return ($urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, lim));
  endfunction

  // One list element; '*' forms only stand alone, since a comma after them is illegal.
  function automatic void put_elem(input int unsigned lim, input bit lone);
    int unsigned kind;
    kind = lone ? $urandom_range(0, 5) : $urandom_range(2, 5);
    case (kind)
      0: spec_q.push_back(CharStar);
      1: begin
        spec_q.push_back(CharStar);
        spec_q.push_back(CharSlash);
        put_num(pick_step(lim));
      end
      2: put_num(pick_num(lim));
      3: begin
        put_num(pick_num(lim));
        spec_q.push_back(CharDash);
        put_num(pick_num(lim));
      end
      4: begin
        put_num(pick_num(lim));
        spec_q.push_back(CharDash);
        put_num(pick_num(lim));
        spec_q.push_back(CharSlash);
        put_num(pick_step(lim));
      end
      default: begin
        put_num(pick_num(lim));
        spec_q.push_back(CharSlash);
        put_num(pick_step(lim));
      end
    endcase
  endfunction

  function automatic void put_blanks();
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 3))
        0:       spec_q.push_back(CharTab);
        1:       spec_q.push_back(CharNewline);
        default: spec_q.push_back(CharSpace);
      endcase
    end
  endfunction

  function automatic void build_spec();
    int unsigned nf;
    int unsigned ne;
    spec_q.delete();
    // Pure noise now and then.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) spec_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) put_blanks();
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 5;
    for (int unsigned f = 0; f < nf; f++) begin
      ne = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1;
      for (int unsigned e = 0; e < ne; e++) begin
        if (e > 0) spec_q.push_back(CharComma);
        put_elem(limit_of(f), ne == 1);
      end
      if (f < nf - 1) put_blanks();
    end
    // Trailing text after the fifth field.
    if (nf == 5 && $urandom_range(0, 5) == 0) begin
      put_blanks();
      repeat ($urandom_range(1, 4)) spec_q.push_back(8'($urandom_range(0, 255)));
    end
    // Stray characters dropped into the text.
    if ($urandom_range(0, 4) == 0)
      spec_q.insert($urandom_range(0, spec_q.size()), 8'($urandom_range(0, 255)));
    // Cut the specification short.
    if ($urandom_range(0, 9) == 0)
      while (spec_q.size() > 1 && $urandom_range(0, 3) != 0) void'(spec_q.pop_back());
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows: text, and the expected masks where they are obvious
  // ---------------------------------------------------------------------------
  string     row_text[$];
  bit        row_known[$];
  out_item_t row_masks[$];

  function automatic void add_row(input string s, input bit known, input out_item_t want);
    row_text.push_back(s);
    row_known.push_back(known);
    row_masks.push_back(want);
  endfunction

  initial begin
    out_item_t   zero_only;
    int unsigned rand_specs;

    clear_parse();
    zero_only = masks_of(1, 1, 1, 1, 1, 1'b0);

    add_row("* * * * *", 1'b1, masks_of('1, '1, '1, '1, '1, 1'b0));
    add_row("59 23 30 11 6", 1'b1, masks_of(60'h1 << 59, 24'h1 << 23, 31'h1 << 30,
                                            12'h1 << 11, 7'h1 << 6, 1'b0));
    add_row("60 24 31 12 7", 1'b1, masks_of('0, '0, '0, '0, '0, 1'b0));
    add_row(" ", 1'b1, zero_only);
    add_row("x", 1'b1, masks_of(1, 1, 1, 1, 1, 1'b1));
    add_row("*/15 0-23/6 1-31/0 */ 5/", 1'b0, '0);
    add_row(",5 -5 5- 9-3 200", 1'b0, '0);
    add_row("0-200 999 3,7,1 1-5/2,9 0-6/", 1'b0, '0);
    add_row("*5 *- *, */2,3 */2-", 1'b0, '0);
    add_row("1/2- 1/2/ 1/2/3 a?b 5", 1'b0, '0);
    add_row("\t 5\n6  7\t8 9 trailing*junk", 1'b0, '0);
    add_row("5 6", 1'b0, '0);
    add_row("12", 1'b0, '0);
    add_row("3 4-", 1'b0, '0);
    add_row("* * * * */", 1'b0, '0);
    add_row("0/0 0/1 0-0 11-11 6-0", 1'b0, '0);
    add_row("*/1 */1 */1 */1 */1", 1'b0, '0);

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the rows.
    for (int r = 0; r < row_text.size(); r++) begin
      spec_q.delete();
      for (int i = 0; i < row_text[r].len(); i++) spec_q.push_back(row_text[r][i]);
      row_typed = row_known[r];
      row_want  = row_masks[r];
      send_spec();
    end
    // NUL and 0xFF cannot sit in a string; both are unexpected at field start.
    spec_q    = '{8'h00, 8'hFF};
    row_typed = 1'b1;
    row_want  = masks_of(1, 1, 1, 1, 1, 1'b1);
    send_spec();
    row_typed = 1'b0;

    // Random part: mostly well-formed text, some noise and broken sequences.
    chars_sent = 0;
    rand_specs = 0;
    while (chars_sent < RandomChars || rand_specs < RandomSpecs) begin
      if (chars_sent >= QuietFrom) quiet = 1'b1;
      build_spec();
      send_spec();
      rand_specs++;
    end
    in_valid <= 1'b0;

    // Drain the outstanding masks, then allow for a stray late transfer.
    while (pending_masks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### cron_field_mask_parser.f
+incdir+rtl
rtl/cfmp_pkg.sv
rtl/cfmp_front.sv
rtl/cfmp_queue.sv
rtl/cfmp_back.sv
rtl/cron_field_mask_parser.sv
dv/cron_field_mask_parser_tb.sv
